/* rtl/core/wspd_pkg.sv */
// ----------------------------------------------------------------------------
// Weather sensor pulse-distance transmitter package
// Shared types and constants: symbol phases, operation and register codes,
// and the words carried on the item, result and configuration channels.
// ----------------------------------------------------------------------------
package wspd_pkg;

	localparam int FRAME_BITS = 36;
	localparam int POS_BITS   = 6;
	localparam int LEN_BITS   = 16;
	localparam int REP_BITS   = 8;
	localparam int CFG_IDX_BITS = 3;
	localparam int CFG_DATA_BITS = 16;

	// Bit position that marks the sync symbol between frames.
	localparam logic [POS_BITS-1:0] SYNC_POS = POS_BITS'(FRAME_BITS);

	localparam logic [0:0] OP_TICK  = 1'b0;
	localparam logic [0:0] OP_START = 1'b1;

	localparam logic [CFG_IDX_BITS-1:0] CFG_HIGH_TICKS     = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_ONE_GAP_TICKS  = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] CFG_ZERO_GAP_TICKS = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] CFG_SYNC_GAP_TICKS = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] CFG_REPEAT_VALUE   = 3'd4;

	localparam logic [LEN_BITS-1:0] HIGH_TICKS_RST     = 16'd500;
	localparam logic [LEN_BITS-1:0] ONE_GAP_TICKS_RST  = 16'd2000;
	localparam logic [LEN_BITS-1:0] ZERO_GAP_TICKS_RST = 16'd1000;
	localparam logic [LEN_BITS-1:0] SYNC_GAP_TICKS_RST = 16'd4000;
	localparam logic [REP_BITS-1:0] REPEAT_VALUE_RST   = 8'd10;

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_HIGH = 2'd1,
		PH_GAP  = 2'd2,
		PH_SYNC = 2'd3
	} phase_t;

	typedef struct packed {
		logic [0:0]         op;
		logic [7:0]         sensor_id;
		logic               battery_ok;
		logic [1:0]         channel;
		logic signed [11:0] temperature_tenths;
		logic [7:0]         humidity;
	} item_t;

	typedef struct packed {
		logic line_level;
		logic busy_res;
		logic start_ignored;
		logic packet_done;
	} result_t;

endpackage

/* rtl/core/wspd_stream_if.sv */
// ----------------------------------------------------------------------------
// Stream channel
// Valid/ready channel carrying one word of a given type per handshake.
// ----------------------------------------------------------------------------
interface wspd_stream_if #(
	parameter type T = logic
) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

/* rtl/core/wspd_cfg_if.sv */
// ----------------------------------------------------------------------------
// Configuration write channel
// Valid/ready channel carrying a register index and its write data.
// ----------------------------------------------------------------------------
interface wspd_cfg_if
	import wspd_pkg::*;
();
	logic                     valid;
	logic                     ready;
	logic [CFG_IDX_BITS-1:0]  index;
	logic [CFG_DATA_BITS-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/core/weather_sensor_pulse_distance_tx.sv */
// ----------------------------------------------------------------------------
// Weather sensor pulse-distance transmitter
// Sends a 36-bit sensor frame as high pulses followed by low gaps whose
// length codes each bit, repeated with a sync symbol between frames.
// ----------------------------------------------------------------------------
// A result word is registered as its item is accepted, via the skid stage
// while the output is stalled. Throughput: one item per cycle while the skid
// stage is empty, so one result can wait to be taken without stopping items.
// Reset: arst_n clears the phase, bit and frame counters, ticks and result
// valid flags at once and loads the default lengths and repeat count.
module weather_sensor_pulse_distance_tx
	import wspd_pkg::*;
#(
	parameter int TICK_COUNT_BITS = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	wspd_stream_if.sink   item,
	wspd_stream_if.source result,
	wspd_cfg_if.sink      cfg
);

	localparam logic [TICK_COUNT_BITS-1:0] ONE_TICK = TICK_COUNT_BITS'(1);

	// Timing registers
	logic [LEN_BITS-1:0] high_ticks_q;
	logic [LEN_BITS-1:0] one_gap_ticks_q;
	logic [LEN_BITS-1:0] zero_gap_ticks_q;
	logic [LEN_BITS-1:0] sync_gap_ticks_q;
	logic [REP_BITS-1:0] repeat_value_q;

	// Symbol state
	phase_t                     phase_q, phase_nxt;
	logic [FRAME_BITS-1:0]      frame_q, frame_nxt;
	logic [POS_BITS-1:0]        bit_pos_q, bit_pos_nxt, bit_pos_inc;
	logic [REP_BITS-1:0]        frames_left_q, frames_left_nxt, frames_dec;
	logic [TICK_COUNT_BITS-1:0] ticks_q, ticks_nxt;

	// Result buffers
	result_t res_q, skid_q, res_nxt;
	logic    res_valid_q, skid_valid_q;
	logic    item_acc, res_take;

	function automatic logic [TICK_COUNT_BITS-1:0] load_len(input logic [LEN_BITS-1:0] v);
		logic [31:0] w;
		logic [31:0] top;
		w   = 32'(v);
		top = (32'd1 << TICK_COUNT_BITS) - 32'd1;
		if (w > top) begin
			w = top;
		end
		if (w == 32'd0) begin
			w = 32'd1;
		end
		return w[TICK_COUNT_BITS-1:0];
	endfunction

	assign item.ready   = !skid_valid_q;
	assign item_acc     = item.valid && item.ready;
	assign res_take     = res_valid_q && result.ready;
	assign result.valid = res_valid_q;
	assign result.data  = res_q;
	assign cfg.ready    = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			high_ticks_q     <= HIGH_TICKS_RST;
			one_gap_ticks_q  <= ONE_GAP_TICKS_RST;
			zero_gap_ticks_q <= ZERO_GAP_TICKS_RST;
			sync_gap_ticks_q <= SYNC_GAP_TICKS_RST;
			repeat_value_q   <= REPEAT_VALUE_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_HIGH_TICKS:     high_ticks_q     <= cfg.data;
				CFG_ONE_GAP_TICKS:  one_gap_ticks_q  <= cfg.data;
				CFG_ZERO_GAP_TICKS: zero_gap_ticks_q <= cfg.data;
				CFG_SYNC_GAP_TICKS: sync_gap_ticks_q <= cfg.data;
				CFG_REPEAT_VALUE:   repeat_value_q   <= cfg.data[REP_BITS-1:0];
				default: ;
			endcase
		end
	end

	assign bit_pos_inc = bit_pos_q + POS_BITS'(1);
	assign frames_dec  = frames_left_q - REP_BITS'(1);

	always_comb begin
		phase_nxt       = phase_q;
		frame_nxt       = frame_q;
		bit_pos_nxt     = bit_pos_q;
		frames_left_nxt = frames_left_q;
		ticks_nxt       = ticks_q;
		res_nxt         = '0;

		if (item_acc) begin
			if (item.data.op == OP_START) begin
				if (phase_q != PH_IDLE) begin
					res_nxt.start_ignored = 1'b1;
				end else if (repeat_value_q >= REP_BITS'(2)) begin
					// Frame bit 0 sits in the MSB and goes out first.
					frame_nxt = {item.data.sensor_id, item.data.battery_ok, 1'b0,
						item.data.channel, item.data.temperature_tenths, 4'hF,
						item.data.humidity};
					frames_left_nxt = repeat_value_q - REP_BITS'(1);
					bit_pos_nxt     = '0;
					phase_nxt       = PH_HIGH;
					ticks_nxt       = load_len(high_ticks_q);
				end
				res_nxt.line_level = (phase_nxt == PH_HIGH);
			end else if (phase_q != PH_IDLE) begin
				res_nxt.line_level = (phase_q == PH_HIGH);
				if (ticks_q > ONE_TICK) begin
					ticks_nxt = ticks_q - ONE_TICK;
				end else begin
					case (phase_q)
						PH_HIGH: begin
							if (bit_pos_q < SYNC_POS) begin
								phase_nxt = PH_GAP;
								ticks_nxt = load_len(frame_q[FRAME_BITS-1] ?
									one_gap_ticks_q : zero_gap_ticks_q);
							end else begin
								phase_nxt = PH_SYNC;
								ticks_nxt = load_len(sync_gap_ticks_q);
							end
						end
						PH_GAP: begin
							// Rotating keeps the frame intact for the next repeat.
							frame_nxt = {frame_q[FRAME_BITS-2:0], frame_q[FRAME_BITS-1]};
							if (bit_pos_inc < SYNC_POS) begin
								bit_pos_nxt = bit_pos_inc;
								phase_nxt   = PH_HIGH;
								ticks_nxt   = load_len(high_ticks_q);
							end else begin
								frames_left_nxt = frames_dec;
								if (frames_dec == '0) begin
									phase_nxt           = PH_IDLE;
									bit_pos_nxt         = '0;
									ticks_nxt           = '0;
									res_nxt.packet_done = 1'b1;
								end else begin
									bit_pos_nxt = SYNC_POS;
									phase_nxt   = PH_HIGH;
									ticks_nxt   = load_len(high_ticks_q);
								end
							end
						end
						PH_SYNC: begin
							bit_pos_nxt = '0;
							phase_nxt   = PH_HIGH;
							ticks_nxt   = load_len(high_ticks_q);
						end
						default: ;
					endcase
				end
			end
		end
		res_nxt.busy_res = (phase_nxt != PH_IDLE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_IDLE;
			bit_pos_q     <= '0;
			frames_left_q <= '0;
			ticks_q       <= '0;
		end else begin
			phase_q       <= phase_nxt;
			bit_pos_q     <= bit_pos_nxt;
			frames_left_q <= frames_left_nxt;
			ticks_q       <= ticks_nxt;
		end
	end

	always_ff @(posedge clk) begin
		frame_q <= frame_nxt;
	end

	// A new word goes to the skid stage only while the output word is stalled.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (item_acc) begin
			if (res_valid_q && !res_take) begin
				skid_valid_q <= 1'b1;
			end else begin
				res_valid_q <= 1'b1;
			end
		end else if (res_take) begin
			if (skid_valid_q) begin
				skid_valid_q <= 1'b0;
			end else begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_acc) begin
			if (res_valid_q && !res_take) begin
				skid_q <= res_nxt;
			end else begin
				res_q <= res_nxt;
			end
		end else if (res_take && skid_valid_q) begin
			res_q <= skid_q;
		end
	end

	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> res_valid_q)
		else $error("skid word held without an output word");

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q != PH_IDLE) |-> (bit_pos_q <= SYNC_POS))
		else $error("bit position beyond sync mark");

	a_frames_left: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q != PH_IDLE) |-> (frames_left_q != '0))
		else $error("busy with no frames left");

	a_ticks_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q != PH_IDLE) |-> (ticks_q != '0))
		else $error("active phase with empty tick count");

endmodule

/* tb/wspd_line_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Pulse-distance line checker
// Watches the item, result and configuration channels of the transmitter.
// Every accepted item advances a private copy of the symbol timer and
// queues the result word it should cause; every accepted result word is
// compared field by field with the oldest queued word.
// ----------------------------------------------------------------------------
module wspd_line_checker
	import wspd_pkg::*;
#(
	parameter int TICK_COUNT_BITS = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     item_valid,
	input  logic                     item_ready,
	input  item_t                    item_data,
	input  logic                     result_valid,
	input  logic                     result_ready,
	input  result_t                  result_data,
	input  logic                     cfg_valid,
	input  logic                     cfg_ready,
	input  logic [CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [CFG_DATA_BITS-1:0] cfg_data,
	output int                       mismatches,
	output int                       pending,
	output logic                     line_busy
);

	localparam int REPORT_CAP = 40;

	// Timing registers as the block should hold them.
	logic [LEN_BITS-1:0] high_len, one_len, zero_len, sync_len;
	logic [REP_BITS-1:0] repeat_bound;

	// Symbol state.
	phase_t                phase;
	logic [FRAME_BITS-1:0] frame_bits;
	logic [POS_BITS-1:0]   bit_pos;
	logic [REP_BITS-1:0]   frames_to_go;
	int unsigned           ticks_to_go;

	result_t predicted_words[$];
	result_t made_word, want_word;
	int      words_checked;

	task automatic report_mismatch(input string msg);
		if (mismatches < REPORT_CAP)
			$display("error at %0t, result word %0d: %s", $time, words_checked, msg);
		mismatches++;
	endtask

	// A zero length still lasts one tick; a length beyond the counter saturates.
	function automatic int unsigned phase_length(input logic [LEN_BITS-1:0] len);
		longint unsigned top, n;
		top = (64'd1 << TICK_COUNT_BITS) - 64'd1;
		n = len;
		if (n > top)
			n = top;
		if (n == 0)
			n = 1;
		return int'(n);
	endfunction

	task automatic clear_line();
		high_len     = HIGH_TICKS_RST;
		one_len      = ONE_GAP_TICKS_RST;
		zero_len     = ZERO_GAP_TICKS_RST;
		sync_len     = SYNC_GAP_TICKS_RST;
		repeat_bound = REPEAT_VALUE_RST;
		phase        = PH_IDLE;
		frame_bits   = '0;
		bit_pos      = '0;
		frames_to_go = '0;
		ticks_to_go  = 0;
	endtask

	task automatic write_timing(input logic [CFG_IDX_BITS-1:0] idx,
			input logic [CFG_DATA_BITS-1:0] value);
		case (idx)
			CFG_HIGH_TICKS:     high_len = value;
			CFG_ONE_GAP_TICKS:  one_len = value;
			CFG_ZERO_GAP_TICKS: zero_len = value;
			CFG_SYNC_GAP_TICKS: sync_len = value;
			CFG_REPEAT_VALUE:   repeat_bound = value[REP_BITS-1:0];
			default: ;
		endcase
	endtask

	// One item moves a busy line by one tick, or latches a frame on a start from idle.
	task automatic advance_line(input item_t w, output result_t r);
		r = '0;
		if (w.op == OP_START) begin
			if (phase != PH_IDLE) begin
				r.start_ignored = 1'b1;
			end else if (repeat_bound >= 2) begin
				frame_bits   = {w.sensor_id, w.battery_ok, 1'b0, w.channel,
					w.temperature_tenths, 4'hF, w.humidity};
				frames_to_go = repeat_bound - 1'b1;
				bit_pos      = '0;
				phase        = PH_HIGH;
				ticks_to_go  = phase_length(high_len);
			end
			r.line_level = (phase == PH_HIGH);
		end else if (phase != PH_IDLE) begin
			r.line_level = (phase == PH_HIGH);
			if (ticks_to_go > 1) begin
				ticks_to_go--;
			end else begin
				case (phase)
					PH_HIGH: begin
						if (bit_pos < FRAME_BITS) begin
							phase = PH_GAP;
							ticks_to_go = phase_length(frame_bits[FRAME_BITS-1-int'(bit_pos)] ?
								one_len : zero_len);
						end else begin
							phase = PH_SYNC;
							ticks_to_go = phase_length(sync_len);
						end
					end
					PH_GAP: begin
						bit_pos = bit_pos + 1'b1;
						if (bit_pos < FRAME_BITS) begin
							phase = PH_HIGH;
							ticks_to_go = phase_length(high_len);
						end else begin
							frames_to_go = frames_to_go - 1'b1;
							if (frames_to_go == 0) begin
								phase = PH_IDLE;
								bit_pos = '0;
								ticks_to_go = 0;
								r.packet_done = 1'b1;
							end else begin
								// The sync symbol reuses the high phase at a marker position.
								bit_pos = SYNC_POS;
								phase = PH_HIGH;
								ticks_to_go = phase_length(high_len);
							end
						end
					end
					default: begin
						bit_pos = '0;
						phase = PH_HIGH;
						ticks_to_go = phase_length(high_len);
					end
				endcase
			end
		end
		r.busy_res = (phase != PH_IDLE);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_line();
			predicted_words.delete();
			words_checked = 0;
			mismatches = 0;
			pending <= 0;
			line_busy <= 1'b0;
		end else begin
			if (result_valid && result_ready) begin
				if (predicted_words.size() == 0) begin
					report_mismatch("result word arrived with none pending");
				end else begin
					want_word = predicted_words.pop_front();
					if (result_data.line_level !== want_word.line_level)
						report_mismatch($sformatf("line_level %b, want %b",
							result_data.line_level, want_word.line_level));
					if (result_data.busy_res !== want_word.busy_res)
						report_mismatch($sformatf("busy_res %b, want %b",
							result_data.busy_res, want_word.busy_res));
					if (result_data.start_ignored !== want_word.start_ignored)
						report_mismatch($sformatf("start_ignored %b, want %b",
							result_data.start_ignored, want_word.start_ignored));
					if (result_data.packet_done !== want_word.packet_done)
						report_mismatch($sformatf("packet_done %b, want %b",
							result_data.packet_done, want_word.packet_done));
				end
				words_checked++;
			end
			if (cfg_valid && cfg_ready)
				write_timing(cfg_index, cfg_data);
			if (item_valid && item_ready) begin
				advance_line(item_data, made_word);
				predicted_words.push_back(made_word);
			end
			pending <= predicted_words.size();
			line_busy <= (phase != PH_IDLE);
		end
	end

endmodule

/* tb/tb_weather_sensor_pulse_distance_tx.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Weather sensor pulse-distance transmitter testbench
// Drives start and tick words with random gaps and result back-pressure,
// moves through several timing settings including long phases and the
// small repeat counts, and lets the line checker judge every result word.
// ----------------------------------------------------------------------------
module tb_weather_sensor_pulse_distance_tx;
	import wspd_pkg::*;

	localparam int TICK_COUNT_BITS = 16;
	localparam int RANDOM_WORDS    = 200;
	localparam int QUIET_LIMIT     = 1000;
	localparam int HOLD_CYCLES     = 150;

	logic clk;
	logic arst_n;

	wspd_stream_if #(.T(item_t))   item_ch ();
	wspd_stream_if #(.T(result_t)) result_ch ();
	wspd_cfg_if                    cfg_ch ();

	int   mismatches;
	int   pending;
	logic line_busy;

	bit tx_eager;
	bit rx_eager;
	int words_sent;

	weather_sensor_pulse_distance_tx #(
		.TICK_COUNT_BITS(TICK_COUNT_BITS)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.item(item_ch),
		.result(result_ch),
		.cfg(cfg_ch)
	);

	wspd_line_checker #(
		.TICK_COUNT_BITS(TICK_COUNT_BITS)
	) i_line_checker (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_ch.valid),
		.item_ready(item_ch.ready),
		.item_data(item_ch.data),
		.result_valid(result_ch.valid),
		.result_ready(result_ch.ready),
		.result_data(result_ch.data),
		.cfg_valid(cfg_ch.valid),
		.cfg_ready(cfg_ch.ready),
		.cfg_index(cfg_ch.index),
		.cfg_data(cfg_ch.data),
		.mismatches(mismatches),
		.pending(pending),
		.line_busy(line_busy)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic item_t random_word(input logic [0:0] op);
		item_t w;
		w = item_t'($urandom);
		w.op = op;
		return w;
	endfunction

	// Mostly very short phases so that whole packets fit into the run.
	function automatic logic [CFG_DATA_BITS-1:0] random_length();
		if ($urandom_range(0, 7) == 0)
			return CFG_DATA_BITS'($urandom_range(3, 9));
		return CFG_DATA_BITS'($urandom_range(0, 2));
	endfunction

	task automatic send_word(input item_t w);
		int gap;
		gap = tx_eager ? 0 : $urandom_range(0, 10);
		if (gap > 0) begin
			item_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.data <= w;
		@(posedge clk);
		while (!item_ch.ready) @(posedge clk);
		words_sent++;
	endtask

	// Stop offering words until every predicted result word has come back.
	task automatic settle();
		item_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
			input logic [CFG_DATA_BITS-1:0] value);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= value;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
	endtask

	task automatic program_timing(input logic [CFG_DATA_BITS-1:0] high,
			input logic [CFG_DATA_BITS-1:0] one_gap,
			input logic [CFG_DATA_BITS-1:0] zero_gap,
			input logic [CFG_DATA_BITS-1:0] sync_gap,
			input logic [CFG_DATA_BITS-1:0] rep);
		settle();
		write_reg(CFG_HIGH_TICKS, high);
		write_reg(CFG_ONE_GAP_TICKS, one_gap);
		write_reg(CFG_ZERO_GAP_TICKS, zero_gap);
		write_reg(CFG_SYNC_GAP_TICKS, sync_gap);
		write_reg(CFG_REPEAT_VALUE, rep);
		cfg_ch.valid <= 1'b0;
	endtask

	// Sends a start and ticks until the line is idle again. A stray start
	// in the middle must be ignored; one that lands after the end begins a
	// new packet, which is then ticked out as well. The busy flag can lag by
	// one word, so idle is only trusted after a plain tick.
	task automatic run_packet(input item_t start_w, input int stray_odds);
		send_word(start_w);
		forever begin
			if (line_busy) begin
				if (stray_odds > 0 && $urandom_range(1, stray_odds) == 1)
					send_word(random_word(OP_START));
				else
					send_word(random_word(OP_TICK));
			end else begin
				send_word(random_word(OP_TICK));
				if (!line_busy)
					break;
			end
		end
	endtask

	initial begin
		item_t w;
		int    mark;
		item_ch.valid = 1'b0;
		item_ch.data = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = CFG_HIGH_TICKS;
		cfg_ch.data = '0;
		tx_eager = 1'b0;
		rx_eager = 1'b0;
		words_sent = 0;
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Tick on an idle line with the reset settings.
		send_word(random_word(OP_TICK));

		// Repeat counts of one and zero send nothing; the upper data bits
		// of the repeat register are dropped.
		program_timing('0, '0, '0, '0, 16'hFF01);
		w = '1;
		run_packet(w, 0);
		program_timing('0, '0, '0, '0, 16'h0000);
		run_packet(random_word(OP_START), 0);

		// Zero lengths act as single ticks.
		program_timing('0, '0, '0, '0, 16'd2);
		w = '0;
		w.op = OP_START;
		run_packet(w, 0);

		// Writes to indexes past the last register change nothing.
		settle();
		for (int i = int'(CFG_REPEAT_VALUE) + 1; i < (1 << CFG_IDX_BITS); i++)
			write_reg(CFG_IDX_BITS'(i), CFG_DATA_BITS'($urandom));
		cfg_ch.valid <= 1'b0;

		// Frequent starts while busy, then the temperature extremes.
		program_timing(16'd1, 16'd2, 16'd1, 16'd1, 16'd2);
		w = '1;
		run_packet(w, 3);
		w = random_word(OP_START);
		w.temperature_tenths = 12'sh800;
		run_packet(w, 0);
		w = random_word(OP_START);
		w.temperature_tenths = 12'sh7FF;
		run_packet(w, 0);

		// Long lengths with a repeat count of one, then a small repeat count, run back to back.
		tx_eager = 1'b1;
		rx_eager = 1'b1;
		program_timing(16'hFFFF, 16'hFFFF, 16'd1, 16'd1, 16'd1);
		run_packet(random_word(OP_START), 0);
		// All ones leaves only the fixed zero bit, so one long gap.
		program_timing(16'd1, 16'd1, 16'd40, 16'd1, 16'd2);
		w = '1;
		run_packet(w, 0);
		rx_eager = 1'b0;

		// Random settings, each with a few packets and some idle ticks.
		mark = words_sent;
		while (words_sent - mark < RANDOM_WORDS) begin
			program_timing(random_length(), random_length(), random_length(),
				random_length(), {8'($urandom), 8'($urandom_range(0, 4))});
			repeat ($urandom_range(1, 2)) begin
				tx_eager = ($urandom_range(0, 3) == 0);
				run_packet(random_word(OP_START), 30);
				repeat ($urandom_range(0, 3)) send_word(random_word(OP_TICK));
			end
		end

		item_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	// Result side: random stalls with calm stretches, and now and then a
	// long hold-off that fills the block and stalls its item side.
	initial begin
		int  stall;
		int  taken;
		bit  lazy;
		result_ch.ready = 1'b0;
		taken = 0;
		lazy = 1'b1;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			if (taken % 64 == 0)
				lazy = ($urandom_range(0, 2) != 0);
			if (taken % 1000 == 500)
				stall = HOLD_CYCLES;
			else
				stall = (lazy && !rx_eager) ? $urandom_range(0, 10) : 0;
			if (stall > 0) begin
				result_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			result_ch.ready <= 1'b1;
			@(posedge clk);
			while (!result_ch.valid) @(posedge clk);
			taken++;
		end
	end

	// Ends the run if no word moves on any channel for too long.
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if (arst_n && !(item_ch.valid && item_ch.ready)
					&& !(result_ch.valid && result_ch.ready)
					&& !(cfg_ch.valid && cfg_ch.ready))
				quiet++;
			else
				quiet = 0;
		end
		$display("Mismatches found");
		$finish;
	end

endmodule

/* weather_sensor_pulse_distance_tx.f */
rtl/core/wspd_pkg.sv
rtl/core/wspd_stream_if.sv
rtl/core/wspd_cfg_if.sv
rtl/core/weather_sensor_pulse_distance_tx.sv
tb/wspd_line_checker.sv
tb/tb_weather_sensor_pulse_distance_tx.sv
